// File: rtl/preemptive_task_scheduler_defines.svh
// Assertion macros for the scheduler RTL.
`ifndef PREEMPTIVE_TASK_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
`define PTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define PTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/pts_pkg.sv
// Types, constants and ranking functions of the task scheduler.
package pts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_W        = 16;
    localparam int NEED_W        = 8;
    localparam int PRIO_W        = 11;
    localparam int WEIGHT_W      = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;
    localparam int PROD_W        = 33;
    localparam int ID_W          = 4;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -11'sd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd20;

    typedef enum logic [1:0] {
        POL_HRRN = 2'd0,
        POL_SJF  = 2'd1,
        POL_PRIO = 2'd2,
        POL_NONE = 2'd3
    } pol_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_MUL,
        CELL_SWAP,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic [NEED_W-1:0]        need;
        logic signed [PRIO_W-1:0] prio;
        logic [NEED_W-1:0]        used;
        logic [TICK_W-1:0]        arrival;
    } task_t;

    typedef struct packed {
        cell_op_t          op;
        logic              ins;
        logic              odd;
        pol_t              policy;
        logic [TICK_W-1:0] tick;
    } cell_ctrl_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] need_time;
    } in_t;

    typedef struct packed {
        logic        load_accepted;
        logic [3:0]  task_id;
        logic        ran_valid;
        logic        finished;
        logic [15:0] finish_tick;
        logic [15:0] turnaround;
        logic        all_done;
    } out_t;

    // cross product term (need_a + wait_a) * wait_b
    function automatic logic [PROD_W-1:0] cross_term(
        input task_t a, input task_t b, input logic [TICK_W-1:0] tick);
        logic [TICK_W-1:0] wa;
        logic [TICK_W-1:0] wb;
        logic [TICK_W:0]   sa;
        wa = tick - a.arrival;
        wb = tick - b.arrival;
        sa = {{(TICK_W+1-NEED_W){1'b0}}, a.need} + {1'b0, wa};
        cross_term = {{(PROD_W-TICK_W-1){1'b0}}, sa} * {{(PROD_W-TICK_W){1'b0}}, wb};
    endfunction

    // a strictly above b; p_ab = cross_term(a,b), p_ba = cross_term(b,a)
    function automatic logic rank_above(
        input pol_t pol, input task_t a, input task_t b,
        input logic [PROD_W-1:0] p_ab, input logic [PROD_W-1:0] p_ba,
        input logic [TICK_W-1:0] tick);
        logic wa0;
        logic wb0;
        wa0 = (tick == a.arrival);
        wb0 = (tick == b.arrival);
        unique case (pol)
            POL_HRRN: rank_above = !wb0 && (wa0 || (p_ab > p_ba));
            POL_SJF:  rank_above = a.used < b.used;
            POL_PRIO: rank_above = a.prio > b.prio;
            default:  rank_above = 1'b0;
        endcase
    endfunction

endpackage

// File: rtl/preemptive_task_scheduler.sv
// Load item: the input beat is taken in idle, then its result goes to the output register.
// Tick item: with two or more tasks ready, an odd-even compare-swap sort over the
// cell row (one phase per ready task, each phase: cross products, then swap); then the
// preemption cross products, the compare and run step, and the output register load.
// One item is in work at a time; a finished beat waits in the output register.
// Reset (aresetn low, synchronous) empties the queue, clears counts and tick.
module preemptive_task_scheduler
    #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pts_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pts_pkg::out_t                     m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    `include "preemptive_task_scheduler_defines.svh"

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SWAP,
        S_PMUL,
        S_PDEC,
        S_OUT
    } state_t;

    state_t                              state_reg;
    pts_pkg::pol_t                       policy_reg;
    logic [pts_pkg::WEIGHT_W-1:0]        weight_reg;
    logic [CNT_W-1:0]                    ready_count_reg;
    logic [CNT_W-1:0]                    loaded_count_reg;
    logic [CNT_W-1:0]                    phase_reg;
    logic                                odd_reg;
    logic [pts_pkg::TICK_W-1:0]          tick_reg;
    logic                                run_valid_reg;
    logic [SLOT_W-1:0]                   run_slot_reg;
    pts_pkg::task_t                      run_task_reg;
    logic [pts_pkg::PROD_W-1:0]          p_hr_reg;
    logic [pts_pkg::PROD_W-1:0]          p_rh_reg;
    pts_pkg::out_t                       res_reg;
    logic                                m_valid_reg;
    pts_pkg::out_t                       m_data_reg;

    pts_pkg::cell_ctrl_t                 ctrl;
    pts_pkg::task_t                      inj_task;
    logic [SLOT_W-1:0]                   inj_slot;
    pts_pkg::task_t                      new_task;
    logic [pts_pkg::NEED_W-1:0]          need_fix;
    pts_pkg::task_t                      cell_task [MAX_TASKS];
    logic [SLOT_W-1:0]                   cell_slot [MAX_TASKS];
    logic [MAX_TASKS:0]                  sw_chain;

    logic                                has_ready;
    logic                                dispatch;
    logic                                preempt;
    logic                                runs;
    pts_pkg::task_t                      chosen_task;
    logic [SLOT_W-1:0]                   chosen_slot;
    pts_pkg::task_t                      stepped_task;
    logic                                fin;
    logic [pts_pkg::TICK_W-1:0]          ftick;
    logic [CNT_W-1:0]                    count_after;
    logic                                in_fire;
    logic                                load_ok;
    pts_pkg::out_t                       load_res;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign in_fire   = s_valid && s_ready;
    assign load_ok   = (loaded_count_reg != CNT_MAX);

    // new task record
    always_comb begin
        need_fix = (s_data.need_time == '0) ? 8'd1 : s_data.need_time;
        new_task.need    = need_fix;
        new_task.prio    = $signed({2'b00, weight_reg}) - $signed({3'b000, need_fix});
        new_task.used    = '0;
        new_task.arrival = tick_reg;
    end

    // result of an input beat taken in idle; tick fields are filled later
    always_comb begin
        load_res = '0;
        if (s_data.req_type == pts_pkg::REQ_LOAD) begin
            if (load_ok) begin
                load_res.load_accepted = 1'b1;
                load_res.task_id       = pts_pkg::ID_W'(loaded_count_reg);
                load_res.all_done      = 1'b0;
            end else begin
                load_res.all_done = (ready_count_reg == '0) && !run_valid_reg;
            end
        end
    end

    // dispatch / preempt and the one-tick run step
    always_comb begin
        has_ready = (ready_count_reg != '0);
        dispatch  = has_ready && !run_valid_reg;
        if (has_ready && run_valid_reg) begin
            if (policy_reg == pts_pkg::POL_SJF) begin
                preempt = run_task_reg.need > cell_task[0].need;
            end else begin
                preempt = pts_pkg::rank_above(policy_reg, cell_task[0], run_task_reg,
                                              p_hr_reg, p_rh_reg, tick_reg);
            end
        end else begin
            preempt = 1'b0;
        end
        runs = run_valid_reg || has_ready;
        if (dispatch || preempt) begin
            chosen_task = cell_task[0];
            chosen_slot = cell_slot[0];
        end else begin
            chosen_task = run_task_reg;
            chosen_slot = run_slot_reg;
        end
        stepped_task      = chosen_task;
        stepped_task.prio = (chosen_task.prio == pts_pkg::PRIO_MIN) ?
                            chosen_task.prio : chosen_task.prio - 11'sd1;
        stepped_task.used = chosen_task.used + 8'd1;
        fin   = runs && (stepped_task.used == chosen_task.need);
        ftick = tick_reg + 16'd1;
        count_after = dispatch ? ready_count_reg - CNT_ONE : ready_count_reg;
    end

    // cell row control
    always_comb begin
        ctrl.op     = pts_pkg::CELL_HOLD;
        ctrl.ins    = 1'b0;
        ctrl.odd    = odd_reg;
        ctrl.policy = policy_reg;
        ctrl.tick   = tick_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_data.req_type == pts_pkg::REQ_LOAD) && load_ok) begin
                    ctrl.op = pts_pkg::CELL_APPEND;
                end
            end
            S_MUL:  ctrl.op = pts_pkg::CELL_MUL;
            S_SWAP: ctrl.op = pts_pkg::CELL_SWAP;
            S_PDEC: begin
                if (dispatch || preempt) begin
                    ctrl.op  = pts_pkg::CELL_POP;
                    ctrl.ins = preempt;
                end
            end
            default: ctrl.op = pts_pkg::CELL_HOLD;
        endcase
        if (state_reg == S_IDLE) begin
            inj_task = new_task;
            inj_slot = SLOT_W'(loaded_count_reg);
        end else begin
            inj_task = run_task_reg;
            inj_slot = run_slot_reg;
        end
    end

    assign sw_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        pts_pkg::task_t    lt;
        logic [SLOT_W-1:0] ls;
        pts_pkg::task_t    rt;
        logic [SLOT_W-1:0] rs;
        if (g == 0) begin : g_first
            assign lt = '0;
            assign ls = '0;
        end else begin : g_mid
            assign lt = cell_task[g-1];
            assign ls = cell_slot[g-1];
        end
        if (g == MAX_TASKS - 1) begin : g_last
            assign rt = '0;
            assign rs = '0;
        end else begin : g_inner
            assign rt = cell_task[g+1];
            assign rs = cell_slot[g+1];
        end
        pts_cell #(
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .idx        (CNT_W'(g)),
            .count      (ready_count_reg),
            .ctrl       (ctrl),
            .inj_task   (inj_task),
            .inj_slot   (inj_slot),
            .left_task  (lt),
            .left_slot  (ls),
            .right_task (rt),
            .right_slot (rs),
            .sw_in      (sw_chain[g]),
            .sw_out     (sw_chain[g+1]),
            .ent_task   (cell_task[g]),
            .ent_slot   (cell_slot[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            policy_reg       <= pts_pkg::POL_PRIO;
            weight_reg       <= pts_pkg::WEIGHT_RST;
            ready_count_reg  <= '0;
            loaded_count_reg <= '0;
            phase_reg        <= '0;
            odd_reg          <= 1'b0;
            tick_reg         <= '0;
            run_valid_reg    <= 1'b0;
            run_slot_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == pts_pkg::CFG_POLICY) begin
                    policy_reg <= pts_pkg::pol_t'(cfg_wdata[1:0]);
                end else if (cfg_index == pts_pkg::CFG_WEIGHT) begin
                    weight_reg <= cfg_wdata[pts_pkg::WEIGHT_W-1:0];
                end
            end
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        res_reg   <= load_res;
                        phase_reg <= '0;
                        odd_reg   <= 1'b0;
                        if (s_data.req_type == pts_pkg::REQ_LOAD) begin
                            if (load_ok) begin
                                ready_count_reg  <= ready_count_reg + CNT_ONE;
                                loaded_count_reg <= loaded_count_reg + CNT_ONE;
                            end
                            state_reg <= S_OUT;
                        end else if (ready_count_reg > CNT_ONE) begin
                            state_reg <= S_MUL;
                        end else begin
                            state_reg <= S_PMUL;
                        end
                    end
                end
                S_MUL: state_reg <= S_SWAP;
                S_SWAP: begin
                    odd_reg   <= !odd_reg;
                    phase_reg <= phase_reg + CNT_ONE;
                    if (phase_reg + CNT_ONE >= ready_count_reg) begin
                        state_reg <= S_PMUL;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_PMUL: begin
                    p_hr_reg  <= pts_pkg::cross_term(cell_task[0], run_task_reg, tick_reg);
                    p_rh_reg  <= pts_pkg::cross_term(run_task_reg, cell_task[0], tick_reg);
                    state_reg <= S_PDEC;
                end
                S_PDEC: begin
                    ready_count_reg <= count_after;
                    tick_reg        <= ftick;
                    run_valid_reg   <= runs && !fin;
                    run_slot_reg    <= chosen_slot;
                    run_task_reg    <= stepped_task;
                    res_reg.load_accepted <= 1'b0;
                    res_reg.task_id     <= runs ? pts_pkg::ID_W'(chosen_slot) : '0;
                    res_reg.ran_valid   <= runs;
                    res_reg.finished    <= fin;
                    res_reg.finish_tick <= fin ? ftick : '0;
                    res_reg.turnaround  <= fin ? ftick - chosen_task.arrival : '0;
                    res_reg.all_done    <= (count_after == '0) && !(runs && !fin);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PTS_ASSERT_IMP(a_count_le_loaded, aclk, aresetn, 1'b1, ready_count_reg <= loaded_count_reg)
    `PTS_ASSERT_NXT(a_out_fill, aclk, aresetn, (state_reg == S_OUT) && (!m_valid_reg || m_ready), m_valid_reg)
    `PTS_ASSERT_IMP(a_fin_ran, aclk, aresetn, m_valid_reg, !m_data_reg.finished || m_data_reg.ran_valid)
    `PTS_ASSERT_IMP(a_load_no_run, aclk, aresetn, m_valid_reg, !(m_data_reg.load_accepted && m_data_reg.ran_valid))

endmodule

// File: rtl/pts_cell.sv
// One ready-queue cell: holds a task, compare-swaps with its right neighbor, and loads on append and pop.
module pts_cell #(
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic                 aclk,
    input  logic [CNT_W-1:0]     idx,
    input  logic [CNT_W-1:0]     count,
    input  pts_pkg::cell_ctrl_t  ctrl,
    input  pts_pkg::task_t       inj_task,
    input  logic [SLOT_W-1:0]    inj_slot,
    input  pts_pkg::task_t       left_task,
    input  logic [SLOT_W-1:0]    left_slot,
    input  pts_pkg::task_t       right_task,
    input  logic [SLOT_W-1:0]    right_slot,
    input  logic                 sw_in,
    output logic                 sw_out,
    output pts_pkg::task_t       ent_task,
    output logic [SLOT_W-1:0]    ent_slot
);

    pts_pkg::task_t               task_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [pts_pkg::PROD_W-1:0]   p_rs_reg;
    logic [pts_pkg::PROD_W-1:0]   p_sr_reg;
    logic                         is_left;
    logic                         above;

    assign ent_task = task_reg;
    assign ent_slot = slot_reg;

    assign is_left = (idx[0] == ctrl.odd) &&
                     (({1'b0, idx} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, count});
    assign above   = pts_pkg::rank_above(ctrl.policy, right_task, task_reg,
                                         p_rs_reg, p_sr_reg, ctrl.tick);
    assign sw_out  = (ctrl.op == pts_pkg::CELL_SWAP) && is_left && above;

    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            pts_pkg::CELL_HOLD: begin
            end
            pts_pkg::CELL_APPEND: begin
                if (idx == count) begin
                    task_reg <= inj_task;
                    slot_reg <= inj_slot;
                end
            end
            pts_pkg::CELL_MUL: begin
                p_rs_reg <= pts_pkg::cross_term(right_task, task_reg, ctrl.tick);
                p_sr_reg <= pts_pkg::cross_term(task_reg, right_task, ctrl.tick);
            end
            pts_pkg::CELL_SWAP: begin
                if (sw_out) begin
                    task_reg <= right_task;
                    slot_reg <= right_slot;
                end else if (sw_in) begin
                    task_reg <= left_task;
                    slot_reg <= left_slot;
                end
            end
            pts_pkg::CELL_POP: begin
                if (ctrl.ins && (idx == count - {{(CNT_W-1){1'b0}}, 1'b1})) begin
                    task_reg <= inj_task;
                    slot_reg <= inj_slot;
                end else begin
                    task_reg <= right_task;
                    slot_reg <= right_slot;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
